@@ rtl/vldrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vldrc_pkg
// Shared types and sizes of the visit log distinct range counter.
// ----------------------------------------------------------------------------
package vldrc_pkg;

    // Sizes of the two tables
    localparam int LOG_DEPTH    = 65536;
    localparam int CLIENT_COUNT = 65536;

    localparam int LOG_AW = $clog2(LOG_DEPTH);       // log entry index
    localparam int LOG_CW = $clog2(LOG_DEPTH + 1);   // fill count of the log
    localparam int CLI_AW = $clog2(CLIENT_COUNT);    // client table index

    // Field widths of the item and result
    localparam int ID_W  = 16;
    localparam int IDX_W = 16;
    localparam int RES_W = 17;

    // Per-client visit count, saturating
    localparam int              CNT_W   = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    // Item codes as seen on the input
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Classified operation
    typedef enum logic [1:0] {
        OP_ADD,
        OP_QUERY,
        OP_ERR
    } t_op;

    // Back-end sequencer
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_QRY
    } t_state;

    // One queued command
    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   visitor_id;
        logic [IDX_W-1:0]  range_start;
        logic [IDX_W-1:0]  range_end;
        logic [LOG_AW-1:0] pos;        // log slot an add will fill
    } t_cmd;

    // Client table entry; a nonzero count marks a valid last visit
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [LOG_AW-1:0] last;
    } t_cli_ent;

    // Log entry: previous visit of the same client
    typedef struct packed {
        logic              valid;
        logic [LOG_AW-1:0] prev;
    } t_log_ent;

endpackage
`default_nettype wire

@@ rtl/vldrc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vldrc_front
// Input handshake and classification. Tracks the log fill level so every
// item is checked against the log as it will be when it executes.
// ----------------------------------------------------------------------------
module vldrc_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic                      i_cmd,
    input  wire logic [vldrc_pkg::ID_W-1:0]  i_visitor_id,
    input  wire logic [vldrc_pkg::IDX_W-1:0] i_range_start,
    input  wire logic [vldrc_pkg::IDX_W-1:0] i_range_end,
    input  wire logic                      i_cq_full,
    input  wire logic                      i_clearing,
    output logic                           o_cq_push,
    output vldrc_pkg::t_cmd                o_cq_data
);

    logic [vldrc_pkg::LOG_CW-1:0] r_log_count;
    logic [vldrc_pkg::LOG_CW-1:0] n_log_count;
    logic                         log_full;
    logic                         id_bad;
    logic                         range_bad;

    assign full      = i_cq_full | i_clearing;
    assign o_cq_push = push & ~full;

    assign log_full  = r_log_count >= vldrc_pkg::LOG_CW'(vldrc_pkg::LOG_DEPTH);
    assign id_bad    = 32'(i_visitor_id) >= vldrc_pkg::CLIENT_COUNT;
    assign range_bad = (i_range_start > i_range_end) ||
                       (32'(i_range_end) >= 32'(r_log_count));

    always_comb begin
        o_cq_data.visitor_id  = i_visitor_id;
        o_cq_data.range_start = i_range_start;
        o_cq_data.range_end   = i_range_end;
        o_cq_data.pos         = vldrc_pkg::LOG_AW'(r_log_count);
        n_log_count           = r_log_count;
        if (i_cmd == vldrc_pkg::CMD_ADD) begin
            if (log_full || id_bad) begin
                o_cq_data.op = vldrc_pkg::OP_ERR;
            end else begin
                o_cq_data.op = vldrc_pkg::OP_ADD;
                if (o_cq_push) begin
                    n_log_count = r_log_count + 1'b1;
                end
            end
        end else begin
            o_cq_data.op = range_bad ? vldrc_pkg::OP_ERR : vldrc_pkg::OP_QUERY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_count <= '0;
        end else begin
            r_log_count <= n_log_count;
        end
    end

endmodule
`default_nettype wire

@@ rtl/vldrc_cq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vldrc_cq
// Small command queue between the front and the back end.
// ----------------------------------------------------------------------------
module vldrc_cq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  vldrc_pkg::t_cmd      i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output vldrc_pkg::t_cmd      o_data
);

    vldrc_pkg::t_cmd                r_mem [vldrc_pkg::CQ_DEPTH];
    logic [vldrc_pkg::CQ_AW-1:0]    r_wptr;
    logic [vldrc_pkg::CQ_AW-1:0]    r_rptr;
    logic [vldrc_pkg::CQ_CW-1:0]    r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = r_count == vldrc_pkg::CQ_CW'(vldrc_pkg::CQ_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == vldrc_pkg::CQ_AW'(vldrc_pkg::CQ_DEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == vldrc_pkg::CQ_AW'(vldrc_pkg::CQ_DEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/vldrc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vldrc_back
// Execution engine: clears the client table after reset, performs adds as a
// read-modify-write of the client table, walks query ranges through the log,
// and holds the result register.
// ----------------------------------------------------------------------------
module vldrc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cq_empty,
    input  vldrc_pkg::t_cmd                    i_cq_head,
    output logic                               o_cq_pop,
    output logic                               o_clearing,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [vldrc_pkg::RES_W-1:0]        o_visit_number,
    output logic [vldrc_pkg::RES_W-1:0]        o_unique_count,
    output logic [vldrc_pkg::RES_W-1:0]        o_range_length,
    output logic                               o_error
);

    // Memories
    vldrc_pkg::t_cli_ent cli_mem [vldrc_pkg::CLIENT_COUNT];
    vldrc_pkg::t_log_ent log_mem [vldrc_pkg::LOG_DEPTH];

    vldrc_pkg::t_state              r_state, n_state;
    logic [vldrc_pkg::CLI_AW-1:0]   r_clr_addr, n_clr_addr;
    logic [vldrc_pkg::CLI_AW-1:0]   r_id, n_id;
    logic [vldrc_pkg::LOG_AW-1:0]   r_pos, n_pos;
    logic [vldrc_pkg::LOG_AW-1:0]   r_idx, n_idx;
    logic [vldrc_pkg::IDX_W-1:0]    r_start, n_start;
    logic [vldrc_pkg::LOG_AW-1:0]   r_end, n_end;
    logic [vldrc_pkg::RES_W-1:0]    r_uniq, n_uniq;

    logic                           r_out_valid, n_out_valid;
    logic [vldrc_pkg::RES_W-1:0]    r_visit, n_visit;
    logic [vldrc_pkg::RES_W-1:0]    r_unique, n_unique;
    logic [vldrc_pkg::RES_W-1:0]    r_length, n_length;
    logic                           r_error, n_error;

    vldrc_pkg::t_cli_ent            r_cli_rd;
    vldrc_pkg::t_log_ent            r_log_rd;

    logic                           cli_we;
    logic [vldrc_pkg::CLI_AW-1:0]   cli_waddr;
    vldrc_pkg::t_cli_ent            cli_wdata;
    logic                           log_we;
    vldrc_pkg::t_log_ent            log_wdata;
    logic [vldrc_pkg::LOG_AW-1:0]   log_raddr;

    logic                           out_free;
    logic                           hit;
    logic [vldrc_pkg::RES_W-1:0]    uniq_sum;
    logic [vldrc_pkg::CNT_W-1:0]    cnt_new;

    assign out_free   = ~r_out_valid | pop;
    assign empty      = ~r_out_valid;
    assign o_clearing = r_state == vldrc_pkg::ST_CLEAR;

    assign o_visit_number = r_visit;
    assign o_unique_count = r_unique;
    assign o_range_length = r_length;
    assign o_error        = r_error;

    // Entry counts when its client has no earlier visit at or after start
    assign hit      = ~r_log_rd.valid || (32'(r_log_rd.prev) < 32'(r_start));
    assign uniq_sum = r_uniq + vldrc_pkg::RES_W'(hit);
    assign cnt_new  = (r_cli_rd.cnt == vldrc_pkg::CNT_MAX) ?
                      r_cli_rd.cnt : r_cli_rd.cnt + 1'b1;

    assign log_raddr = (r_state == vldrc_pkg::ST_IDLE) ?
                       vldrc_pkg::LOG_AW'(i_cq_head.range_start) : r_idx + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_id        = r_id;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_start     = r_start;
        n_end       = r_end;
        n_uniq      = r_uniq;
        n_out_valid = r_out_valid & ~pop;
        n_visit     = r_visit;
        n_unique    = r_unique;
        n_length    = r_length;
        n_error     = r_error;
        o_cq_pop    = 1'b0;
        cli_we      = 1'b0;
        cli_waddr   = r_id;
        cli_wdata   = '{cnt: cnt_new, last: r_pos};
        log_we      = 1'b0;
        log_wdata   = '{valid: r_cli_rd.cnt != '0, prev: r_cli_rd.last};

        unique case (r_state)
            vldrc_pkg::ST_CLEAR: begin
                cli_we     = 1'b1;
                cli_waddr  = r_clr_addr;
                cli_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == vldrc_pkg::CLI_AW'(vldrc_pkg::CLIENT_COUNT - 1)) begin
                    n_state = vldrc_pkg::ST_IDLE;
                end
            end
            vldrc_pkg::ST_IDLE: begin
                if (!i_cq_empty && out_free) begin
                    o_cq_pop = 1'b1;
                    unique case (i_cq_head.op)
                        vldrc_pkg::OP_ADD: begin
                            n_id    = vldrc_pkg::CLI_AW'(i_cq_head.visitor_id);
                            n_pos   = i_cq_head.pos;
                            n_state = vldrc_pkg::ST_ADD;
                        end
                        vldrc_pkg::OP_QUERY: begin
                            n_idx   = vldrc_pkg::LOG_AW'(i_cq_head.range_start);
                            n_start = i_cq_head.range_start;
                            n_end   = vldrc_pkg::LOG_AW'(i_cq_head.range_end);
                            n_uniq  = '0;
                            n_state = vldrc_pkg::ST_QRY;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_visit     = '0;
                            n_unique    = '0;
                            n_length    = '0;
                            n_error     = 1'b1;
                        end
                    endcase
                end
            end
            vldrc_pkg::ST_ADD: begin
                cli_we      = 1'b1;
                log_we      = 1'b1;
                n_out_valid = 1'b1;
                n_visit     = vldrc_pkg::RES_W'(cnt_new);
                n_unique    = '0;
                n_length    = '0;
                n_error     = 1'b0;
                n_state     = vldrc_pkg::ST_IDLE;
            end
            vldrc_pkg::ST_QRY: begin
                if (r_idx == r_end) begin
                    n_out_valid = 1'b1;
                    n_visit     = '0;
                    n_unique    = uniq_sum;
                    n_length    = vldrc_pkg::RES_W'(r_end) -
                                  vldrc_pkg::RES_W'(r_start) + 1'b1;
                    n_error     = 1'b0;
                    n_state     = vldrc_pkg::ST_IDLE;
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_uniq = uniq_sum;
                end
            end
            default: begin
                n_state = vldrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vldrc_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_start  <= n_start;
        r_end    <= n_end;
        r_uniq   <= n_uniq;
        r_visit  <= n_visit;
        r_unique <= n_unique;
        r_length <= n_length;
        r_error  <= n_error;
    end

    // Client table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (cli_we) begin
            cli_mem[cli_waddr] <= cli_wdata;
        end
        if (r_state == vldrc_pkg::ST_IDLE) begin
            r_cli_rd <= cli_mem[vldrc_pkg::CLI_AW'(i_cq_head.visitor_id)];
        end
    end

    // Log: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (log_we) begin
            log_mem[r_pos] <= log_wdata;
        end
        r_log_rd <= log_mem[log_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/visit_log_distinct_range_counter_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// visit_log_distinct_range_counter_top
// Append-only client visit log with distinct-client range queries.
// ----------------------------------------------------------------------------
// After reset the block sweeps its client table to zero, one entry per cycle,
// so it holds full high for the whole sweep, before the first
// transfer. An add (i_cmd = 0) appends a log entry for i_visitor_id, records
// that client's previous visit beside it and returns the new visit count
// (saturating at 131071) in o_visit_number. A query (i_cmd = 1) returns in
// o_unique_count the number of distinct clients in log entries
// i_range_start..i_range_end inclusive, and the range size in
// o_range_length. An add to a full log, or a query whose start is after its
// end or whose end is past the last entry, returns o_error = 1 with the
// other fields zero and changes nothing. In the back end, an add is a
// client table read, then a write of table and log; a query walks its
// range, reading one log entry per cycle through the log memory's single
// read port; an error goes straight to the result register. A two-entry
// command queue sits between input classification and execution, and the
// result register is separate, so new items are taken while a result
// waits to be popped. Results come out in input order, one per item.
// ----------------------------------------------------------------------------
module visit_log_distinct_range_counter_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input queue side
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_cmd,
    input  wire logic [vldrc_pkg::ID_W-1:0]    i_visitor_id,
    input  wire logic [vldrc_pkg::IDX_W-1:0]   i_range_start,
    input  wire logic [vldrc_pkg::IDX_W-1:0]   i_range_end,
    // result queue side
    output logic                               empty,
    input  wire logic                          pop,
    output logic [vldrc_pkg::RES_W-1:0]        o_visit_number,
    output logic [vldrc_pkg::RES_W-1:0]        o_unique_count,
    output logic [vldrc_pkg::RES_W-1:0]        o_range_length,
    output logic                               o_error
);

    // front -> queue
    logic            cq_push;
    vldrc_pkg::t_cmd cq_wdata;
    logic            cq_full;
    // queue -> back
    logic            cq_empty;
    logic            cq_pop;
    vldrc_pkg::t_cmd cq_head;
    // back -> front: client table sweep in progress
    logic            clearing;

    // Classifies each item and keeps the log fill level used for checks
    vldrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_visitor_id  (i_visitor_id),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_cq_full     (cq_full),
        .i_clearing    (clearing),
        .o_cq_push     (cq_push),
        .o_cq_data     (cq_wdata)
    );

    // Decouples classification from execution
    vldrc_cq u_cq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_data  (cq_wdata),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_empty (cq_empty),
        .o_data  (cq_head)
    );

    // Client table, log memory and result register
    vldrc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cq_empty     (cq_empty),
        .i_cq_head      (cq_head),
        .o_cq_pop       (cq_pop),
        .o_clearing     (clearing),
        .pop            (pop),
        .empty          (empty),
        .o_visit_number (o_visit_number),
        .o_unique_count (o_unique_count),
        .o_range_length (o_range_length),
        .o_error        (o_error)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb - visit log distinct range counter testbench
// Directed table, then random adds and queries, then wide ranges over the log.
// A predictor mirrors the client table and the log, and every popped result
// is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD = 12;
    localparam int N_RANDOM   = 360;
    localparam int N_DIRECTED = 20;
    localparam int MAX_REPORT = 10;

    // Sizes and codes taken from the package
    localparam int LOG_DEPTH    = vldrc_pkg::LOG_DEPTH;
    localparam int CLIENT_COUNT = vldrc_pkg::CLIENT_COUNT;
    localparam int LOG_AW       = vldrc_pkg::LOG_AW;
    localparam int LOG_CW       = vldrc_pkg::LOG_CW;
    localparam int ID_W         = vldrc_pkg::ID_W;
    localparam int IDX_W        = vldrc_pkg::IDX_W;
    localparam int RES_W        = vldrc_pkg::RES_W;
    localparam int CNT_W        = vldrc_pkg::CNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = vldrc_pkg::CNT_MAX;
    localparam logic CMD_ADD    = vldrc_pkg::CMD_ADD;
    localparam logic CMD_QUERY  = vldrc_pkg::CMD_QUERY;

    // One input transfer
    typedef struct packed {
        logic             cmd;
        logic [ID_W-1:0]  visitor_id;
        logic [IDX_W-1:0] range_start;
        logic [IDX_W-1:0] range_end;
    } t_visit_item;

    // One result transfer
    typedef struct packed {
        logic [RES_W-1:0] visit_number;
        logic [RES_W-1:0] unique_count;
        logic [RES_W-1:0] range_length;
        logic             error;
    } t_log_reply;

    // Directed row; typed = 1 means the reply below is the expected one
    typedef struct packed {
        logic             cmd;
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             typed;
        logic [RES_W-1:0] visits;
        logic [RES_W-1:0] uniq;
        logic [RES_W-1:0] span;
        logic             err;
    } t_directed_row;

    // Short directed run. Log after the last add of the table holds, by index:
    //   0:id 0, 1:id ffff, 2:id 0, 3:id 5555, 4:id aaaa, 5:id ffff, 6:id 0
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        // queries on an empty log: range past end
        '{CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 17'd0, 17'd0, 17'd0, 1'b1},
        '{CMD_QUERY, 16'h0000, 16'hffff, 16'hffff, 1'b1, 17'd0, 17'd0, 17'd0, 1'b1},
        // first visits and a repeat, id extremes
        '{CMD_ADD,   16'h0000, 16'h0000, 16'h0000, 1'b1, 17'd1, 17'd0, 17'd0, 1'b0},
        '{CMD_ADD,   16'hffff, 16'hffff, 16'hffff, 1'b1, 17'd1, 17'd0, 17'd0, 1'b0},
        '{CMD_ADD,   16'h0000, 16'h1234, 16'h0001, 1'b1, 17'd2, 17'd0, 17'd0, 1'b0},
        '{CMD_QUERY, 16'hffff, 16'h0000, 16'h0000, 1'b1, 17'd0, 17'd1, 17'd1, 1'b0},
        '{CMD_QUERY, 16'h0000, 16'h0000, 16'h0002, 1'b1, 17'd0, 17'd2, 17'd3, 1'b0},
        // repeat whose earlier visit falls before the range start
        '{CMD_QUERY, 16'h0000, 16'h0001, 16'h0002, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        // reversed range, end one past the log, reversed extremes
        '{CMD_QUERY, 16'h0000, 16'h0002, 16'h0001, 1'b1, 17'd0, 17'd0, 17'd0, 1'b1},
        '{CMD_QUERY, 16'h0000, 16'h0000, 16'h0003, 1'b1, 17'd0, 17'd0, 17'd0, 1'b1},
        '{CMD_QUERY, 16'h0000, 16'hffff, 16'h0000, 1'b1, 17'd0, 17'd0, 17'd0, 1'b1},
        '{CMD_ADD,   16'h5555, 16'h0000, 16'h0000, 1'b1, 17'd1, 17'd0, 17'd0, 1'b0},
        '{CMD_ADD,   16'haaaa, 16'h0000, 16'h0000, 1'b1, 17'd1, 17'd0, 17'd0, 1'b0},
        '{CMD_ADD,   16'hffff, 16'h0000, 16'h0000, 1'b1, 17'd2, 17'd0, 17'd0, 1'b0},
        '{CMD_ADD,   16'h0000, 16'hffff, 16'hffff, 1'b1, 17'd3, 17'd0, 17'd0, 1'b0},
        '{CMD_QUERY, 16'h0000, 16'h0000, 16'h0006, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{CMD_QUERY, 16'h0000, 16'h0003, 16'h0006, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{CMD_QUERY, 16'h0000, 16'h0006, 16'h0006, 1'b1, 17'd0, 17'd1, 17'd1, 1'b0},
        '{CMD_QUERY, 16'h0000, 16'h0000, 16'hffff, 1'b1, 17'd0, 17'd0, 17'd0, 1'b1},
        '{CMD_QUERY, 16'h0000, 16'h0005, 16'h0004, 1'b1, 17'd0, 17'd0, 17'd0, 1'b1}
    };

    // DUT ports; the inputs are known from time zero
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             push          = 1'b0;
    logic             i_cmd         = CMD_ADD;
    logic [ID_W-1:0]  i_visitor_id  = '0;
    logic [IDX_W-1:0] i_range_start = '0;
    logic [IDX_W-1:0] i_range_end   = '0;
    logic             pop           = 1'b0;
    logic             full;
    logic             empty;
    logic [RES_W-1:0] o_visit_number;
    logic [RES_W-1:0] o_unique_count;
    logic [RES_W-1:0] o_range_length;
    logic             o_error;

    // Predictor state: log, per-client table, fill level
    bit [LOG_CW-1:0] log_fill = '0;
    bit [LOG_AW-1:0] prev_visit_at    [LOG_DEPTH];
    bit              prev_visit_known [LOG_DEPTH];
    bit [CNT_W-1:0]  client_visits    [CLIENT_COUNT];
    bit [LOG_AW-1:0] last_visit_of    [CLIENT_COUNT];
    bit              last_visit_known [CLIENT_COUNT];

    t_log_reply      replies_due [$];
    bit [ID_W-1:0]   regulars [16];      // small set of ids so clients come back
    bit              no_idle  = 1'b0;    // when set, neither side inserts waits
    int unsigned     pop_hold = 0;

    int unsigned n_adds     = 0;
    int unsigned n_queries  = 0;
    int unsigned n_rejected = 0;
    int unsigned n_checked  = 0;
    int unsigned n_bad      = 0;

    visit_log_distinct_range_counter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_visitor_id   (i_visitor_id),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .empty          (empty),
        .pop            (pop),
        .o_visit_number (o_visit_number),
        .o_unique_count (o_unique_count),
        .o_range_length (o_range_length),
        .o_error        (o_error)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop, set well past the slowest legal run: the table clear, then
    // 400 items, each with waits on both sides plus a walk no longer than the
    // log built here.
    initial begin
        #(CLK_PERIOD * 2_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    // Apply one item to the predictor state and return the reply it produces.
    // Rejected items leave the state alone.
    function automatic t_log_reply apply_log_item(t_visit_item it);
        t_log_reply      r;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     hits;
        bit [LOG_AW-1:0] slot;
        r = '0;
        if (it.cmd == CMD_ADD) begin
            if (32'(log_fill) >= LOG_DEPTH || 32'(it.visitor_id) >= CLIENT_COUNT) begin
                r.error = 1'b1;
            end else begin
                slot = log_fill[LOG_AW-1:0];
                prev_visit_at[slot]    = last_visit_of[it.visitor_id];
                prev_visit_known[slot] = last_visit_known[it.visitor_id];
                if (client_visits[it.visitor_id] != CNT_MAX)
                    client_visits[it.visitor_id]++;
                last_visit_of[it.visitor_id]    = slot;
                last_visit_known[it.visitor_id] = 1'b1;
                log_fill++;
                r.visit_number = client_visits[it.visitor_id];
            end
        end else begin
            lo = 32'(it.range_start);
            hi = 32'(it.range_end);
            if (lo > hi || hi >= 32'(log_fill)) begin
                r.error = 1'b1;
            end else begin
                // a client counts once, at its first entry inside the range
                hits = 0;
                for (int unsigned i = lo; i <= hi; i++)
                    if (!prev_visit_known[LOG_AW'(i)] ||
                        32'(prev_visit_at[LOG_AW'(i)]) < lo)
                        hits++;
                r.unique_count = RES_W'(hits);
                r.range_length = RES_W'(hi - lo + 1);
            end
        end
        return r;
    endfunction

    // Present one item, hold it until the transfer, then log what is due.
    // push is left high so back-to-back items need no second assignment.
    task automatic send_item(input t_visit_item it, input bit typed,
                             input t_log_reply typed_reply);
        int unsigned gap;
        t_log_reply  r;
        gap = draw_wait();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_cmd         <= it.cmd;
        i_visitor_id  <= it.visitor_id;
        i_range_start <= it.range_start;
        i_range_end   <= it.range_end;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        r = apply_log_item(it);
        replies_due.push_back(typed ? typed_reply : r);
        if (it.cmd == CMD_ADD) n_adds++;
        else                   n_queries++;
        if (r.error) n_rejected++;
    endtask

    function automatic bit [ID_W-1:0] pick_client();
        return ($urandom_range(0, 9) < 7) ? regulars[4'($urandom_range(0, 15))]
                                          : ID_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_add();
        t_visit_item it;
        it             = '0;
        it.cmd         = CMD_ADD;
        it.visitor_id  = pick_client();
        it.range_start = IDX_W'($urandom_range(0, 65535));   // ignored by an add
        it.range_end   = IDX_W'($urandom_range(0, 65535));
        send_item(it, 1'b0, '0);
    endtask

    // Valid queries are mostly short; allow_long permits a rare walk over
    // a range of any length that the log allows.
    task automatic send_query(input bit broken, input bit allow_long);
        t_visit_item it;
        int unsigned fill;
        int unsigned len;
        int unsigned hi;
        it            = '0;
        it.cmd        = CMD_QUERY;
        it.visitor_id = ID_W'($urandom_range(0, 65535));     // ignored by a query
        fill          = 32'(log_fill);
        if (broken || fill == 0) begin
            if (fill < LOG_DEPTH && $urandom_range(0, 1) == 1) begin
                // end at or past the log fill
                hi = $urandom_range(fill, 65535);
                it.range_end   = IDX_W'(hi);
                it.range_start = IDX_W'($urandom_range(0, hi));
            end else begin
                // start after end
                it.range_start = IDX_W'($urandom_range(1, 65535));
                it.range_end   = IDX_W'($urandom_range(0, 32'(it.range_start) - 1));
            end
        end else begin
            if (allow_long && $urandom_range(0, 19) == 0)
                len = $urandom_range(1, fill);
            else
                len = $urandom_range(1, (fill < 32) ? fill : 32);
            hi             = $urandom_range(len - 1, fill - 1);
            it.range_end   = IDX_W'(hi);
            it.range_start = IDX_W'(hi - len + 1);
        end
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_span(input int unsigned lo, input int unsigned hi);
        t_visit_item it;
        it             = '0;
        it.cmd         = CMD_QUERY;
        it.range_start = IDX_W'(lo);
        it.range_end   = IDX_W'(hi);
        send_item(it, 1'b0, '0);
    endtask

    task automatic report_bad(input string what, input t_log_reply want,
                              input t_log_reply got);
        n_bad++;
        if (n_bad <= MAX_REPORT) begin
            $display("tb: %s: expected visit=%0d uniq=%0d len=%0d err=%0d",
                     what, want.visit_number, want.unique_count,
                     want.range_length, want.error);
            $display("tb: %s: actual   visit=%0d uniq=%0d len=%0d err=%0d",
                     what, got.visit_number, got.unique_count,
                     got.range_length, got.error);
        end
    endtask

    // Result side: compare each transfer, then draw a stall before the next.
    always @(posedge i_clk) begin
        t_log_reply got;
        t_log_reply want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = '{o_visit_number, o_unique_count, o_range_length, o_error};
                if (replies_due.size() == 0) begin
                    report_bad("result with none pending", '0, got);
                end else begin
                    want = replies_due.pop_front();
                    n_checked++;
                    if (got !== want)
                        report_bad("mismatch", want, got);
                end
                pop_hold = draw_wait();
            end
            if (pop_hold != 0) begin
                pop <= 1'b0;
                pop_hold--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        t_visit_item it;
        t_log_reply  typed_reply;
        int unsigned top_idx;
        regulars[0] = '0;
        regulars[1] = '1;
        for (int i = 2; i < 16; i++)
            regulars[i] = ID_W'($urandom_range(0, 65535));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the block clears its client table next; the handshake waits it out

        // Directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            it          = '{DIRECTED[i].cmd, DIRECTED[i].id, DIRECTED[i].lo,
                            DIRECTED[i].hi};
            typed_reply = '{DIRECTED[i].visits, DIRECTED[i].uniq, DIRECTED[i].span,
                            DIRECTED[i].err};
            send_item(it, DIRECTED[i].typed, typed_reply);
        end

        // Random part: mostly adds and well-formed queries, some bad ranges.
        // Waits switch off for whole stretches now and then.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 99)) inside
                [0:44]:  send_add();
                [45:84]: send_query(1'b0, 1'b1);
                default: send_query(1'b1, 1'b1);
            endcase
        end

        // Widest and topmost ranges of the log as built, then the whole
        // index space, which lies past the end of the log
        no_idle = 1'b0;
        top_idx = 32'(log_fill) - 1;
        send_span(0, top_idx);
        send_span(top_idx, top_idx);
        send_span(top_idx / 2, top_idx);
        send_span(0, LOG_DEPTH - 1);
        for (int n = 0; n < 16; n++)
            send_query($urandom_range(0, 3) == 0, 1'b0);
        push <= 1'b0;

        // Drain, then allow a short tail for any stray result
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("tb: %0d adds and %0d queries transferred, %0d refused, log at %0d entries",
                 n_adds, n_queries, n_rejected, log_fill);
        $display("tb: %0d results compared, %0d bad", n_checked, n_bad);
        if (n_bad == 0 && replies_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
